### design/hfup_pkg.sv
package hfup_pkg;

    localparam int PIXEL_COUNT_DEF = 64;
    localparam int FRAME_LIMIT_DEF = 40;
    localparam int IDX_W           = 6;
    localparam int CMP_W           = 7;

    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_R  = 8'h52;
    localparam logic [7:0] CH_D  = 8'h44;
    localparam logic [7:0] CH_P  = 8'h50;
    localparam logic [7:0] CH_S  = 8'h53;

    typedef enum logic [1:0] {
        CMD_CHAR  = 2'd0,
        CMD_FWD   = 2'd1,
        CMD_BACK  = 2'd2,
        CMD_PIXEL = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_REPLY = 2'd0,
        KIND_STEP  = 2'd1,
        KIND_PIXEL = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REPLY_R = 2'd0,
        REPLY_A = 2'd1,
        REPLY_K = 2'd2
    } reply_t;

    typedef struct packed {
        logic wr_en;
        logic wr_low;
        logic rd_en;
    } store_ctl_t;

endpackage

### design/hex_frame_upload_player_core.sv
// Results pass through the p1 and output registers. Throughput: one input
// transaction per cycle while in_ready is high; each needs at most one nibble
// write or one byte read of the frame memory, whose read data is registered.
// Reset (rst_n low, asynchronous): no frames, upload and line state cleared,
// frame 0 selected, no result pending. Frame memory contents are not cleared.
module hex_frame_upload_player_core
    import hfup_pkg::*;
#(
    parameter int PIXEL_COUNT = PIXEL_COUNT_DEF,
    parameter int FRAME_LIMIT = FRAME_LIMIT_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       cmd,
    input  logic [7:0]       char_code,
    input  logic [7:0]       byte_index,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       kind,
    output logic [1:0]       reply_code,
    output logic             shown,
    output logic [IDX_W-1:0] frame_index,
    output logic [7:0]       pixel_value
);

    localparam int FRAME_SIZE    = PIXEL_COUNT * 3;
    localparam int FRAME_NIBBLES = FRAME_SIZE * 2;
    localparam int STORE_DEPTH   = FRAME_LIMIT * FRAME_SIZE;
    localparam int PENDING_CAP   = FRAME_NIBBLES + 2;
    localparam int CNT_W         = $clog2(FRAME_LIMIT + 1);
    localparam int HEX_W         = $clog2(FRAME_NIBBLES + 1);
    localparam int PEND_W        = $clog2(PENDING_CAP + 1);
    localparam int SUM_W         = PEND_W + 1;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int BASE_W        = $clog2(STORE_DEPTH + 1);
    localparam int BI_W          = $clog2(FRAME_SIZE + 1) + 8;

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] n;
        n = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            n = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            n = c[3:0] + 4'd9;
        end
        return n;
    endfunction

    logic [CNT_W-1:0]  frame_count_reg, frame_count_next;
    logic [IDX_W-1:0]  cur_index_reg, cur_index_next;
    logic [HEX_W-1:0]  hex_length_reg, hex_length_next;
    logic [PEND_W-1:0] pending_reg, pending_next;
    logic [7:0]        line_cmd_reg, line_cmd_next;
    logic              line_started_reg, line_started_next;
    logic              last_cr_reg, last_cr_next;
    logic [BASE_W-1:0] frame_base_reg, frame_base_next;
    logic [BASE_W-1:0] cur_base_reg, cur_base_next;

    logic              p1_valid_reg, p1_valid_next;
    kind_t             p1_kind_reg;
    reply_t            p1_reply_reg;
    logic              p1_shown_reg;
    logic [IDX_W-1:0]  p1_idx_reg;
    logic              p1_pix_ok_reg;

    logic              out_valid_reg, out_valid_next;
    kind_t             kind_reg;
    reply_t            reply_reg;
    logic              shown_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [7:0]        pixel_reg;

    logic              accept;
    logic              p1_move;
    cmd_t              cmd_in;
    logic              res_load;
    kind_t             res_kind;
    reply_t            res_reply;
    logic              res_shown;
    logic [IDX_W-1:0]  res_idx;
    logic              res_pix_ok;

    logic [CMP_W-1:0]  cnt_x;
    logic [CMP_W-1:0]  cur_x;
    logic              has_frames;
    logic              cur_in_range;
    logic              room;
    logic [CMP_W-1:0]  norm_idx;
    logic [BASE_W-1:0] norm_base;
    logic [CMP_W-1:0]  idx_plus;
    logic [SUM_W-1:0]  pos;
    logic [BASE_W:0]   wsum;
    logic [BASE_W:0]   rsum;
    logic              pix_ok;
    logic              plen_nz;
    logic              line_empty;
    logic [PEND_W-1:0] plen;
    logic [SUM_W-1:0]  d_sum;

    store_ctl_t        store_ctl;
    logic [7:0]        rd_byte;

    assign accept   = in_valid && in_ready;
    assign p1_move  = p1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !p1_valid_reg || !out_valid_reg || out_ready;
    assign cmd_in   = cmd_t'(cmd);

    assign cnt_x        = CMP_W'(frame_count_reg);
    assign cur_x        = CMP_W'(cur_index_reg);
    assign has_frames   = (frame_count_reg != '0);
    assign cur_in_range = (cur_x < cnt_x);
    assign room         = (cnt_x < CMP_W'(FRAME_LIMIT));
    assign norm_idx     = cur_in_range ? cur_x : '0;
    assign norm_base    = cur_in_range ? cur_base_reg : '0;
    assign idx_plus     = norm_idx + CMP_W'(1);

    assign pos  = SUM_W'(hex_length_reg) + SUM_W'(pending_reg);
    assign wsum = (BASE_W + 1)'(frame_base_reg) + (BASE_W + 1)'(pos[SUM_W-1:1]);
    assign rsum = (BASE_W + 1)'(cur_base_reg) + (BASE_W + 1)'(byte_index);
    assign pix_ok = has_frames && cur_in_range && (BI_W'(byte_index) < BI_W'(FRAME_SIZE));

    assign plen_nz    = (pending_reg != '0);
    assign line_empty = !line_started_reg || (last_cr_reg && !plen_nz);
    assign plen       = (last_cr_reg && plen_nz) ? pending_reg - PEND_W'(1) : pending_reg;
    assign d_sum      = SUM_W'(hex_length_reg) + SUM_W'(plen);

    always_comb
    begin
        frame_count_next  = frame_count_reg;
        cur_index_next    = cur_index_reg;
        hex_length_next   = hex_length_reg;
        pending_next      = pending_reg;
        line_cmd_next     = line_cmd_reg;
        line_started_next = line_started_reg;
        last_cr_next      = last_cr_reg;
        frame_base_next   = frame_base_reg;
        cur_base_next     = cur_base_reg;
        store_ctl         = '0;
        res_load          = 1'b0;
        res_kind          = KIND_REPLY;
        res_reply         = REPLY_R;
        res_shown         = 1'b0;
        res_idx           = cur_index_reg;
        res_pix_ok        = 1'b0;

        if (accept)
        begin
            unique case (cmd_in)
                CMD_CHAR:
                begin
                    if (char_code == CH_LF)
                    begin
                        line_started_next = 1'b0;
                        line_cmd_next     = '0;
                        pending_next      = '0;
                        last_cr_next      = 1'b0;
                        if (!line_empty)
                        begin
                            unique case (line_cmd_reg)
                                CH_R:
                                begin
                                    frame_count_next = '0;
                                    hex_length_next  = '0;
                                    cur_index_next   = '0;
                                    frame_base_next  = '0;
                                    cur_base_next    = '0;
                                    res_load         = 1'b1;
                                    res_reply        = REPLY_R;
                                    res_idx          = '0;
                                end
                                CH_D:
                                begin
                                    if (plen_nz && (plen != '0)
                                        && (d_sum <= SUM_W'(FRAME_NIBBLES)))
                                    begin
                                        hex_length_next = HEX_W'(d_sum);
                                    end
                                end
                                CH_P:
                                begin
                                    if ((hex_length_reg >= HEX_W'(FRAME_NIBBLES)) && room)
                                    begin
                                        frame_count_next = frame_count_reg + CNT_W'(1);
                                        frame_base_next  = frame_base_reg + BASE_W'(FRAME_SIZE);
                                    end
                                    hex_length_next = '0;
                                    res_load        = 1'b1;
                                    res_reply       = REPLY_A;
                                end
                                CH_S:
                                begin
                                    cur_index_next = '0;
                                    cur_base_next  = '0;
                                    res_load       = 1'b1;
                                    res_reply      = REPLY_K;
                                    res_shown      = has_frames;
                                    res_idx        = '0;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                    else
                    begin
                        if (!line_started_reg)
                        begin
                            line_started_next = 1'b1;
                            line_cmd_next     = char_code;
                        end
                        else
                        begin
                            if ((line_cmd_reg == CH_D) && (pos < SUM_W'(FRAME_NIBBLES)) && room)
                            begin
                                store_ctl.wr_en  = 1'b1;
                                store_ctl.wr_low = pos[0];
                            end
                            if (pending_reg < PEND_W'(PENDING_CAP))
                            begin
                                pending_next = pending_reg + PEND_W'(1);
                            end
                        end
                        last_cr_next = (char_code == CH_CR);
                    end
                end
                CMD_FWD, CMD_BACK:
                begin
                    res_load = 1'b1;
                    res_kind = KIND_STEP;
                    if (has_frames)
                    begin
                        res_shown = 1'b1;
                        if (cmd_in == CMD_FWD)
                        begin
                            if (idx_plus == cnt_x)
                            begin
                                cur_index_next = '0;
                                cur_base_next  = '0;
                            end
                            else
                            begin
                                cur_index_next = IDX_W'(idx_plus);
                                cur_base_next  = norm_base + BASE_W'(FRAME_SIZE);
                            end
                        end
                        else
                        begin
                            if (norm_idx == '0)
                            begin
                                cur_index_next = IDX_W'(cnt_x - CMP_W'(1));
                                cur_base_next  = frame_base_reg - BASE_W'(FRAME_SIZE);
                            end
                            else
                            begin
                                cur_index_next = IDX_W'(norm_idx - CMP_W'(1));
                                cur_base_next  = norm_base - BASE_W'(FRAME_SIZE);
                            end
                        end
                        res_idx = cur_index_next;
                    end
                end
                CMD_PIXEL:
                begin
                    store_ctl.rd_en = 1'b1;
                    res_load        = 1'b1;
                    res_kind        = KIND_PIXEL;
                    res_shown       = has_frames;
                    res_pix_ok      = pix_ok;
                end
            endcase
        end
    end

    always_comb
    begin
        p1_valid_next = p1_valid_reg;
        if (res_load)
        begin
            p1_valid_next = 1'b1;
        end
        else if (p1_move)
        begin
            p1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (p1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg  <= '0;
            cur_index_reg    <= '0;
            hex_length_reg   <= '0;
            pending_reg      <= '0;
            line_cmd_reg     <= '0;
            line_started_reg <= 1'b0;
            last_cr_reg      <= 1'b0;
            frame_base_reg   <= '0;
            cur_base_reg     <= '0;
            p1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            frame_count_reg  <= frame_count_next;
            cur_index_reg    <= cur_index_next;
            hex_length_reg   <= hex_length_next;
            pending_reg      <= pending_next;
            line_cmd_reg     <= line_cmd_next;
            line_started_reg <= line_started_next;
            last_cr_reg      <= last_cr_next;
            frame_base_reg   <= frame_base_next;
            cur_base_reg     <= cur_base_next;
            p1_valid_reg     <= p1_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            p1_kind_reg   <= res_kind;
            p1_reply_reg  <= res_reply;
            p1_shown_reg  <= res_shown;
            p1_idx_reg    <= res_idx;
            p1_pix_ok_reg <= res_pix_ok;
        end
        if (p1_move)
        begin
            kind_reg  <= p1_kind_reg;
            reply_reg <= p1_reply_reg;
            shown_reg <= p1_shown_reg;
            idx_reg   <= p1_idx_reg;
            pixel_reg <= p1_pix_ok_reg ? rd_byte : 8'd0;
        end
    end

    hfup_store #(
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .ctl     (store_ctl),
        .waddr   (wsum[ADDR_W-1:0]),
        .wnib    (nibble_of(char_code)),
        .raddr   (rsum[ADDR_W-1:0]),
        .rd_byte (rd_byte)
    );

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign reply_code  = reply_reg;
    assign shown       = shown_reg;
    assign frame_index = idx_reg;
    assign pixel_value = pixel_reg;

endmodule

### design/hfup_store.sv
module hfup_store
    import hfup_pkg::*;
#(
    parameter int DEPTH = PIXEL_COUNT_DEF * 3 * FRAME_LIMIT_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  store_ctl_t        ctl,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [3:0]        wnib,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rd_byte
);

    logic [3:0] high_mem [DEPTH];
    logic [3:0] low_mem  [DEPTH];
    logic [3:0] rd_hi_reg;
    logic [3:0] rd_lo_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && !ctl.wr_low)
        begin
            high_mem[waddr] <= wnib;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && ctl.wr_low)
        begin
            low_mem[waddr] <= wnib;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_hi_reg <= high_mem[raddr];
            rd_lo_reg <= low_mem[raddr];
        end
    end

    assign rd_byte = {rd_hi_reg, rd_lo_reg};

endmodule

### design/hfup_checker.sv
module hfup_checker
    import hfup_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [1:0]       kind,
    input logic [1:0]       reply_code,
    input logic             shown,
    input logic [IDX_W-1:0] frame_index,
    input logic [7:0]       pixel_value
);

    // hold a stalled result transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(reply_code)
            && $stable(shown) && $stable(frame_index) && $stable(pixel_value))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_PIXEL) |-> (pixel_value == 8'd0))
        else $error("pixel value outside pixel result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_REPLY) && (reply_code == REPLY_R)
            |-> (frame_index == '0) && !shown)
        else $error("reset reply with frame selected");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_STEP) && !shown
            |-> (frame_index == '0) && (reply_code == REPLY_R))
        else $error("empty step moved the index");

endmodule

bind hex_frame_upload_player_core hfup_checker u_checker (.*);

### sim/hex_frame_upload_player_core_tb.sv
`timescale 1ns / 1ps

module hex_frame_upload_player_core_tb;
    import hfup_pkg::*;

    localparam int FRAME_SIZE = PIXEL_COUNT_DEF * 3;
    localparam int FRAME_NIBBLES = FRAME_SIZE * 2;
    localparam int STORE_DEPTH = FRAME_LIMIT_DEF * FRAME_SIZE;
    localparam int LEN_CAP = FRAME_NIBBLES + 2;
    localparam int MAX_WAIT = 18;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 300;

    typedef struct packed {
        kind_t             kind;
        reply_t            reply;
        logic              shown;
        logic [IDX_W-1:0]  index;
        logic [7:0]        pixel;
    } player_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [1:0]       cmd = '0;
    logic [7:0]       char_code = '0;
    logic [7:0]       byte_index = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [1:0]       kind;
    logic [1:0]       reply_code;
    logic             shown;
    logic [IDX_W-1:0] frame_index;
    logic [7:0]       pixel_value;

    hex_frame_upload_player_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .char_code   (char_code),
        .byte_index  (byte_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .reply_code  (reply_code),
        .shown       (shown),
        .frame_index (frame_index),
        .pixel_value (pixel_value)
    );

    always #1 clk = ~clk;

    // shadow copy of the player
    bit [3:0]   hi_nib [STORE_DEPTH];
    bit [3:0]   lo_nib [STORE_DEPTH];
    int         n_frames = 0;
    int         cur_frame = 0;
    int         hex_done = 0;
    int         line_len = 0;
    logic [7:0] line_cmd = '0;
    bit         in_line = 0;
    bit         prev_cr = 0;
    int         peak_frames = 0;

    player_result_t owed_results [$];
    player_result_t head;

    int  errors = 0;
    int  items_sent = 0;
    int  results_checked = 0;
    int  cycles = 0;
    bit  tx_idle = 1;
    bit  rx_idle = 1;
    string hex_set = "0123456789abcdefABCDEF";

    task automatic owe(kind_t k, reply_t r, bit s, logic [7:0] px);
        owed_results.push_back('{k, r, s, IDX_W'(cur_frame), px});
    endtask

    task automatic play_item(cmd_t c, logic [7:0] ch, logic [7:0] bi);
        int pos;
        int addr;
        int plen;
        bit empty;
        bit vis;
        logic [3:0] nib;
        logic [7:0] val;
        case (c)
            CMD_CHAR:
            begin
                if (ch == CH_LF)
                begin
                    plen = line_len;
                    empty = !in_line;
                    if (prev_cr)
                    begin
                        if (plen > 0)
                            plen--;
                        else
                            empty = 1;
                    end
                    if (!empty)
                    begin
                        if (line_cmd == CH_R)
                        begin
                            n_frames = 0;
                            hex_done = 0;
                            cur_frame = 0;
                            owe(KIND_REPLY, REPLY_R, 0, 8'd0);
                        end
                        else if (line_cmd == CH_D)
                        begin
                            if (plen > 0 && hex_done + plen <= FRAME_NIBBLES)
                                hex_done += plen;
                        end
                        else if (line_cmd == CH_P)
                        begin
                            if (hex_done >= FRAME_NIBBLES && n_frames < FRAME_LIMIT_DEF)
                                n_frames++;
                            if (n_frames > peak_frames)
                                peak_frames = n_frames;
                            hex_done = 0;
                            owe(KIND_REPLY, REPLY_A, 0, 8'd0);
                        end
                        else if (line_cmd == CH_S)
                        begin
                            cur_frame = 0;
                            owe(KIND_REPLY, REPLY_K, n_frames > 0, 8'd0);
                        end
                    end
                    in_line = 0;
                    line_cmd = '0;
                    line_len = 0;
                    prev_cr = 0;
                end
                else
                begin
                    if (!in_line)
                    begin
                        in_line = 1;
                        line_cmd = ch;
                    end
                    else
                    begin
                        pos = hex_done + line_len;
                        if (line_cmd == CH_D && pos < FRAME_NIBBLES && n_frames < FRAME_LIMIT_DEF)
                        begin
                            if (ch >= "0" && ch <= "9")
                                nib = 4'(ch - "0");
                            else if (ch >= "a" && ch <= "f")
                                nib = 4'(ch - "a" + 10);
                            else if (ch >= "A" && ch <= "F")
                                nib = 4'(ch - "A" + 10);
                            else
                                nib = 4'd0;
                            addr = n_frames * FRAME_SIZE + pos / 2;
                            if (pos % 2 == 0)
                                hi_nib[addr] = nib;
                            else
                                lo_nib[addr] = nib;
                        end
                        if (line_len < LEN_CAP)
                            line_len++;
                    end
                    prev_cr = (ch == CH_CR);
                end
            end
            CMD_FWD, CMD_BACK:
            begin
                vis = 0;
                if (n_frames > 0)
                begin
                    if (cur_frame >= n_frames)
                        cur_frame = 0;
                    if (c == CMD_FWD)
                        cur_frame = (cur_frame + 1) % n_frames;
                    else
                        cur_frame = (cur_frame + n_frames - 1) % n_frames;
                    vis = 1;
                end
                owe(KIND_STEP, REPLY_R, vis, 8'd0);
            end
            default:
            begin
                vis = n_frames > 0;
                val = 8'd0;
                if (vis && cur_frame < n_frames && bi < FRAME_SIZE)
                begin
                    addr = cur_frame * FRAME_SIZE + bi;
                    val = {hi_nib[addr], lo_nib[addr]};
                end
                owe(KIND_PIXEL, REPLY_R, vis, val);
            end
        endcase
    endtask

    task automatic send_item(cmd_t c, logic [7:0] ch, logic [7:0] bi);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd = c;
        char_code = ch;
        byte_index = bi;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        play_item(c, ch, bi);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_char(logic [7:0] ch);
        send_item(CMD_CHAR, ch, 8'($urandom_range(0, 255)));
    endtask

    task automatic step(bit fwd);
        send_item(fwd ? CMD_FWD : CMD_BACK, 8'($urandom), 8'($urandom));
    endtask

    task automatic read_pixel(logic [7:0] bi);
        send_item(CMD_PIXEL, 8'($urandom), bi);
    endtask

    function automatic logic [7:0] rand_non_lf();
        logic [7:0] ch;
        ch = ($urandom_range(0, 2) == 0) ? CH_CR : 8'($urandom_range(0, 255));
        if (ch == CH_LF)
            ch = 8'd11;
        return ch;
    endfunction

    task automatic send_data_line(int len, bit noisy);
        send_char(CH_D);
        for (int i = 0; i < len; i++)
        begin
            if (noisy && $urandom_range(0, 11) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    step(1'($urandom_range(0, 1)));
                else
                    read_pixel(8'($urandom_range(0, 255)));
            end
            if (noisy && $urandom_range(0, 9) == 0)
                send_char(rand_non_lf());
            else
                send_char(hex_set[$urandom_range(0, 21)]);
        end
        if ($urandom_range(0, 1) == 0)
            send_char(CH_CR);
        send_char(CH_LF);
    endtask

    task automatic upload_frame(bit noisy);
        int remaining;
        int len;
        remaining = FRAME_NIBBLES - hex_done;
        while (remaining > 0)
        begin
            len = $urandom_range(1, remaining < 200 ? remaining : 200);
            send_data_line(len, noisy);
            remaining = FRAME_NIBBLES - hex_done;
        end
        send_char(CH_P);
        send_char(CH_LF);
    endtask

    task automatic wait_drain();
        in_valid = 1'b0;
        while (owed_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic test_empty_player();
        step(1);
        step(0);
        read_pixel(8'd0);
        read_pixel(8'd255);
        send_char(CH_LF);
        send_char(CH_CR);
        send_char(CH_LF);
        send_char("X");
        send_char(8'h00);
        send_char(CH_LF);
        send_char(CH_S);
        send_char(CH_LF);
        send_char(CH_R);
        send_char(8'hFF);
        send_char(CH_LF);
        send_char(CH_D);
        send_char(CH_LF);
        send_char(CH_D);
        send_char(CH_CR);
        send_char(CH_LF);
        send_char(CH_D);
        send_char(CH_CR);
        send_char(CH_CR);
        send_char(CH_LF);
        send_char(CH_P);
        send_char(CH_LF);
        wait_drain();
    endtask

    task automatic test_frame_upload();
        upload_frame(1);
        for (int i = 0; i < FRAME_SIZE; i += 12)
            read_pixel(8'(i));
        step(1);
        read_pixel(8'd0);
        read_pixel(8'(FRAME_SIZE - 1));
        read_pixel(8'(FRAME_SIZE));
        step(0);
        step(0);
        // overflowing line is dropped, the fitting one completes the frame
        send_data_line(300, 0);
        send_data_line(100, 0);
        send_data_line(FRAME_NIBBLES - hex_done, 0);
        send_char(CH_P);
        send_char(CH_LF);
        // line longer than one frame saturates and is dropped
        send_data_line(LEN_CAP + 4, 1);
        send_data_line(10, 0);
        send_char(CH_P);
        send_char(CH_LF);
        send_char(CH_S);
        send_char(CH_LF);
        for (int i = 0; i < 8; i++)
        begin
            step(1'($urandom_range(0, 1)));
            read_pixel(8'($urandom_range(0, FRAME_SIZE - 1)));
        end
        wait_drain();
    endtask

    task automatic test_random_traffic();
        int target;
        int pick;
        int len;
        bit drained;
        drained = 0;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                tx_idle = $urandom_range(0, 3) != 0;
                rx_idle = $urandom_range(0, 3) != 0;
            end
            // hold off the sender until every reply is back
            if (!drained && items_sent > target - RANDOM_ITEMS / 2)
            begin
                wait_drain();
                drained = 1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 12)
                upload_frame(1'($urandom_range(0, 1)));
            else if (pick < 40)
            begin
                if (hex_done > 300 && $urandom_range(0, 2) == 0)
                    len = FRAME_NIBBLES - hex_done + $urandom_range(1, 3);
                else
                    len = $urandom_range(1, 60);
                send_data_line(len, 1'($urandom_range(0, 1)));
            end
            else if (pick < 48)
            begin
                send_char(CH_P);
                repeat ($urandom_range(0, 2)) send_char(rand_non_lf());
                send_char(CH_LF);
            end
            else if (pick < 53)
            begin
                send_char(CH_S);
                send_char(CH_LF);
            end
            else if (pick < 55)
            begin
                send_char(CH_R);
                send_char(CH_LF);
            end
            else if (pick < 69)
                step(1'($urandom_range(0, 1)));
            else if (pick < 85)
            begin
                if ($urandom_range(0, 4) == 0)
                    read_pixel(8'($urandom_range(FRAME_SIZE, 255)));
                else
                    read_pixel(8'($urandom_range(0, FRAME_SIZE - 1)));
            end
            else if (pick < 95)
            begin
                send_char(rand_non_lf());
                repeat ($urandom_range(0, 5)) send_char(rand_non_lf());
                send_char(CH_LF);
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    send_char(CH_CR);
                send_char(CH_LF);
            end
        end
        wait_drain();
    endtask

    task automatic check_field(string fname, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0d index %0d",
                         $time, kind, frame_index);
                errors++;
            end
            else
            begin
                head = owed_results.pop_front();
                check_field("kind", 8'(head.kind), 8'(kind));
                check_field("reply_code", 8'(head.reply), 8'(reply_code));
                check_field("shown", 8'(head.shown), 8'(shown));
                check_field("frame_index", 8'(head.index), 8'(frame_index));
                check_field("pixel_value", head.pixel, pixel_value);
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall > 0)
            begin
                out_ready = 1'b0;
                while (!out_valid)
                    @(negedge clk);
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_empty_player();
        test_frame_upload();
        test_random_traffic();
        $display("Run covered %0d input transactions and %0d checked results,", items_sent,
                 results_checked);
        $display("with up to %0d frames stored and random stalls on both channels.",
                 peak_frames);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
